[design/multibase_seven_segment_scanner_defines.svh]
// assertion macros used by the scanner design file
`ifndef MULTIBASE_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define MULTIBASE_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// checked on every clock edge once reset is released
`define MSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define MSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mss_pkg.sv]
// package with base codes, register indexes and digit/segment decode for the scanner
package mss_pkg;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [1:0] DIGIT_RIGHT  = 2'd0;
	localparam logic [1:0] DIGIT_MIDDLE = 2'd1;
	localparam logic [1:0] DIGIT_LEFT   = 2'd2;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_DWELL    = 1'b1;

	localparam logic [7:0] DEBOUNCE_RESET = 8'd50;
	localparam logic [7:0] DWELL_RESET    = 8'd5;

	localparam logic [7:0] SEG_BLANK = 8'hFF;

	// common-anode segment patterns, zero lights a segment
	function automatic logic [7:0] seg_decode(logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'h0: s = 8'hC0;
			4'h1: s = 8'hF9;
			4'h2: s = 8'hA4;
			4'h3: s = 8'hB0;
			4'h4: s = 8'h99;
			4'h5: s = 8'h92;
			4'h6: s = 8'h82;
			4'h7: s = 8'hF8;
			4'h8: s = 8'h80;
			4'h9: s = 8'h90;
			4'hA: s = 8'h88;
			4'hB: s = 8'h83;
			4'hC: s = 8'hC6;
			4'hD: s = 8'hA1;
			4'hE: s = 8'h86;
			4'hF: s = 8'h8E;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// one digit of v in the given base at the given position
	function automatic logic [3:0] digit_sel(logic [7:0] v, logic [1:0] mode, logic [1:0] pos);
		logic [1:0]  hundreds;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		logic [3:0]  d;
		if (v >= 8'd200) begin
			hundreds = 2'd2;
			rem      = 7'(v - 8'd200);
		end else if (v >= 8'd100) begin
			hundreds = 2'd1;
			rem      = 7'(v - 8'd100);
		end else begin
			hundreds = 2'd0;
			rem      = v[6:0];
		end
		// divide by ten through reciprocal multiply, exact below 1029
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = rem - 7'(tens) * 7'd10;
		case (mode)
			BASE_OCT: begin
				case (pos)
					DIGIT_RIGHT:  d = {1'b0, v[2:0]};
					DIGIT_MIDDLE: d = {1'b0, v[5:3]};
					default:      d = {2'b00, v[7:6]};
				endcase
			end
			BASE_HEX: begin
				d = (pos == DIGIT_RIGHT) ? v[3:0] : v[7:4];
			end
			default: begin
				case (pos)
					DIGIT_RIGHT:  d = ones[3:0];
					DIGIT_MIDDLE: d = tens;
					default:      d = {2'b00, hundreds};
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

[design/multibase_seven_segment_scanner.sv]
// Multibase seven-segment scanner: mode button debounce, digit split and display scan.
// Input stream (s_*): one transaction per display tick, carrying the switch byte and the
// raw mode button level. Output stream (m_*): one transaction per tick with the segment
// byte (common anode, zero lights), the one-hot anode select and the base in force.
// APB port: register 0 at address 0 is the debounce count, register 1 at address 4 the
// dwell count; the user must write both only while the block is idle, which the block does not enforce.
// Each accepted tick updates the button debounce, latches the switch byte at the start of
// a scan round, decodes the current digit and advances the dwell counter, all in the
// cycle it is accepted. The result is registered in the output register, or in the skid
// register when the output register is full and not taken; throughput one tick per cycle
// while the skid entry is empty.
// When the receiver stalls, the output register holds its result and a one-entry skid
// register takes one more tick; s_tready falls only while that skid entry is full.
// Reset clears mode to decimal, all counters and the latched byte, empties both output
// entries and restores the register defaults (debounce 50, dwell 5).
module multibase_seven_segment_scanner #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] switch_value, [8] button_level, [15:9] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] segment_code, [10:8] anode_enable, [12:11] base_mode
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mss_pkg::*;

	`include "multibase_seven_segment_scanner_defines.svh"

	localparam int LIM_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [1:0] base_mode;
		logic [2:0] anode_enable;
		logic [7:0] segment_code;
	} result_t;

	logic [7:0]             debounce_q;
	logic [7:0]             dwell_ticks_q;
	logic [1:0]             mode_q;
	logic [COUNT_WIDTH-1:0] press_q;
	logic                   await_q;
	logic [1:0]             scan_q;
	logic [COUNT_WIDTH-1:0] dwell_q;
	logic [7:0]             latched_q;

	logic                   out_valid_q;
	result_t                out_q;
	logic                   skid_valid_q;
	result_t                skid_q;

	logic [7:0]             in_switch;
	logic                   in_button;
	logic                   accept;
	logic                   out_take;

	logic [LIM_W-1:0]       deb_limit;
	logic [LIM_W-1:0]       dwell_limit;
	logic [COUNT_WIDTH-1:0] press_inc;
	logic [COUNT_WIDTH-1:0] dwell_inc;
	logic [1:0]             mode_d;
	logic [COUNT_WIDTH-1:0] press_d;
	logic                   await_d;
	logic [1:0]             pos;
	logic [1:0]             scan_d;
	logic [COUNT_WIDTH-1:0] dwell_d;
	logic [7:0]             latched_d;
	logic [3:0]             digit;
	result_t                res;

	assign in_switch = s_tdata[7:0];
	assign in_button = s_tdata[8];

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_take = out_valid_q && m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q};

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RESET;
			dwell_ticks_q <= DWELL_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_DEBOUNCE: debounce_q    <= pwdata[7:0];
				REG_DWELL:    dwell_ticks_q <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DEBOUNCE: prdata = {24'd0, debounce_q};
			REG_DWELL:    prdata = {24'd0, dwell_ticks_q};
			default:      prdata = '0;
		endcase
	end

	// tick limits clamped to the counter range
	always_comb begin
		deb_limit   = LIM_W'(debounce_q);
		dwell_limit = LIM_W'(dwell_ticks_q);
		if (deb_limit > LIM_W'(COUNT_MAX))
			deb_limit = LIM_W'(COUNT_MAX);
		if (dwell_limit > LIM_W'(COUNT_MAX))
			dwell_limit = LIM_W'(COUNT_MAX);
	end

	// next state and result for the incoming tick
	always_comb begin
		press_inc = (press_q == COUNT_MAX) ? press_q : press_q + 1'b1;
		dwell_inc = (dwell_q == COUNT_MAX) ? dwell_q : dwell_q + 1'b1;

		mode_d  = mode_q;
		press_d = press_q;
		await_d = await_q;
		if (!in_button) begin
			press_d = '0;
			await_d = 1'b0;
		end else if (!await_q) begin
			press_d = press_inc;
			if (LIM_W'(press_inc) >= deb_limit) begin
				mode_d  = (mode_q >= BASE_HEX) ? BASE_DEC : mode_q + 2'd1;
				press_d = '0;
				await_d = 1'b1;
			end
		end

		pos       = (scan_q > DIGIT_LEFT) ? DIGIT_RIGHT : scan_q;
		latched_d = (pos == DIGIT_RIGHT && dwell_q == '0) ? in_switch : latched_q;

		digit            = digit_sel(latched_d, mode_d, pos);
		res.base_mode    = mode_d;
		if (mode_d == BASE_HEX && pos == DIGIT_LEFT) begin
			res.segment_code = SEG_BLANK;
			res.anode_enable = 3'b000;
		end else begin
			res.segment_code = seg_decode(digit);
			res.anode_enable = 3'(3'b001 << pos);
		end

		if (LIM_W'(dwell_inc) >= dwell_limit) begin
			dwell_d = '0;
			scan_d  = (pos >= DIGIT_LEFT) ? DIGIT_RIGHT : pos + 2'd1;
		end else begin
			dwell_d = dwell_inc;
			scan_d  = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= BASE_DEC;
			press_q   <= '0;
			await_q   <= 1'b0;
			scan_q    <= DIGIT_RIGHT;
			dwell_q   <= '0;
			latched_q <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			press_q   <= press_d;
			await_q   <= await_d;
			scan_q    <= scan_d;
			dwell_q   <= dwell_d;
			latched_q <= latched_d;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take)
				skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q || out_take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take)
				out_q <= skid_q;
		end else if (accept) begin
			if (!out_valid_q || out_take)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	`MSS_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry full with empty output register")
	`MSS_ASSERT(a_blank_only_hex, (out_valid_q && out_q.anode_enable == 3'b000) |-> (out_q.base_mode == BASE_HEX), "digit blanked outside hex mode")
	`MSS_ASSERT(a_mode_step_waits, !$stable(mode_q) |-> await_q, "mode advanced without waiting for release")
	`MSS_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!out_valid_q && !skid_valid_q), "output entries valid during reset")

endmodule

[tb/sv/multibase_seven_segment_scanner_test.sv]
// testbench for the multibase seven-segment scanner: directed table, random button runs, live predictor
`timescale 1ns / 100ps

module multibase_seven_segment_scanner_test;
	import mss_pkg::*;

	typedef struct packed {
		logic [7:0] segments;
		logic [2:0] anodes;
		logic [1:0] base;
	} display_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic       reg_index;
		logic [7:0] value;      // switch byte for a tick, register value for a write
		logic       button;
		logic       typed;      // expected display given in the row
		display_t   want;
	} row_t;

	// glyphs for 0..F, common anode
	localparam logic [15:0][7:0] GLYPHS = {
		8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
		8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] switch_value, [8] button_level, [15:9] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] segment_code, [10:8] anode_enable, [12:11] base_mode
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	multibase_seven_segment_scanner dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of the scanner state and registers
	logic [7:0] debounce_reg = DEBOUNCE_RESET;
	logic [7:0] dwell_reg    = DWELL_RESET;
	logic [1:0] base_now     = BASE_DEC;
	logic [7:0] press_ticks  = 8'd0;
	logic       held_done    = 1'b0;
	logic [1:0] scan_pos     = DIGIT_RIGHT;
	logic [7:0] lit_ticks    = 8'd0;
	logic [7:0] shown_value  = 8'd0;

	display_t expected_displays [$];
	int       mismatch_count = 0;
	bit       traffic_gaps   = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [3:0] digit_at(logic [7:0] v, logic [1:0] base, logic [1:0] pos);
		logic [3:0] d;
		case (base)
			BASE_OCT: begin
				if (pos == DIGIT_RIGHT)
					d = 4'(v & 8'd7);
				else if (pos == DIGIT_MIDDLE)
					d = 4'((v >> 3) & 8'd7);
				else
					d = 4'(v >> 6);
			end
			BASE_HEX: d = (pos == DIGIT_RIGHT) ? v[3:0] : v[7:4];
			default: begin
				if (pos == DIGIT_RIGHT)
					d = 4'(v % 8'd10);
				else if (pos == DIGIT_MIDDLE)
					d = 4'((v / 8'd10) % 8'd10);
				else
					d = 4'(v / 8'd100);
			end
		endcase
		return d;
	endfunction

	// one display tick: button debounce, round latch, digit decode, dwell advance
	function automatic display_t predict_display(logic [7:0] sw, logic btn);
		display_t r;
		if (!btn) begin
			press_ticks = 8'd0;
			held_done   = 1'b0;
		end else if (!held_done) begin
			if (press_ticks != 8'hFF)
				press_ticks = press_ticks + 8'd1;
			if (press_ticks >= debounce_reg) begin
				base_now    = (base_now >= BASE_HEX) ? BASE_DEC : base_now + 2'd1;
				press_ticks = 8'd0;
				held_done   = 1'b1;
			end
		end
		if (scan_pos > DIGIT_LEFT)
			scan_pos = DIGIT_RIGHT;
		if (scan_pos == DIGIT_RIGHT && lit_ticks == 8'd0)
			shown_value = sw;
		r.base = base_now;
		if (base_now == BASE_HEX && scan_pos == DIGIT_LEFT) begin
			r.segments = SEG_BLANK;
			r.anodes   = 3'b000;
		end else begin
			r.segments = GLYPHS[digit_at(shown_value, base_now, scan_pos)];
			r.anodes   = 3'b001 << scan_pos;
		end
		if (lit_ticks != 8'hFF)
			lit_ticks = lit_ticks + 8'd1;
		if (lit_ticks >= dwell_reg) begin
			lit_ticks = 8'd0;
			scan_pos  = (scan_pos >= DIGIT_LEFT) ? DIGIT_RIGHT : scan_pos + 2'd1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < 40)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		display_t got;
		display_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tdata[10:8], m_tdata[12:11]};
			if (expected_displays.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, 16'h0);
			end else begin
				want = expected_displays.pop_front();
				if (got.segments !== want.segments)
					report_mismatch("segment_code", 16'(got.segments), 16'(want.segments));
				if (got.anodes !== want.anodes)
					report_mismatch("anode_enable", 16'(got.anodes), 16'(want.anodes));
				if (got.base !== want.base)
					report_mismatch("base_mode", 16'(got.base), 16'(want.base));
			end
		end
	end

	// receiver back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (traffic_gaps && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// entered and left at a falling edge; valid stays up for a following tick
	task automatic send_tick(input logic [7:0] sw, input logic btn, input logic typed,
			input display_t want);
		display_t predicted;
		if (traffic_gaps && $urandom_range(0, 11) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, btn, sw};
		do @(posedge clk); while (!s_tready);
		predicted = predict_display(sw, btn);
		expected_displays.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		while (expected_displays.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic index, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (index == REG_DEBOUNCE)
			debounce_reg = value;
		else
			dwell_reg = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_switch();
		logic [7:0] v;
		case ($urandom_range(0, 15))
			0: v = 8'd0;
			1: v = 8'd255;
			2: v = 8'd99;
			3: v = 8'd100;
			4: v = 8'd199;
			5: v = 8'd200;
			default: v = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	initial begin
		row_t script [$];
		int   deb_plan [8];
		int   dwell_plan [8];
		int   budget_plan [8];
		int   lim;
		int   hold;
		int   sent;
		int   k;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 16'd0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = 3'd0;
		pwdata   = 32'd0;

		script = '{
			'{ROW_TICK,  '0, 8'd255, 1'b0, 1'b1, '{8'h92, 3'b001, BASE_DEC}},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b1, '{8'h92, 3'b001, BASE_DEC}},
			'{ROW_WRITE, REG_DEBOUNCE, 8'd1, 1'b0, 1'b0, '0},
			'{ROW_WRITE, REG_DWELL,    8'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b0, '0},
			'{ROW_TICK,  '0, 8'hAB,  1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b1, '{SEG_BLANK, 3'b000, BASE_HEX}},
			'{ROW_TICK,  '0, 8'hFF,  1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b1, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd199, 1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd200, 1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd100, 1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd99,  1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0},
			'{ROW_TICK,  '0, 8'd0,   1'b0, 1'b0, '0}
		};

		// debounce, dwell, ticks per setting; zero registers behave as one
		deb_plan    = '{50, 1, 0, 255, 2, 4, 0, 3};
		dwell_plan  = '{5, 1, 0, 1, 255, 2, 0, 3};
		budget_plan = '{200, 200, 150, 350, 300, 250, 250, 230};
		deb_plan[6]   = $urandom_range(1, 20);
		dwell_plan[6] = $urandom_range(1, 8);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				drain_results();
				write_register(script[i].reg_index, script[i].value);
			end else begin
				send_tick(script[i].value, script[i].button, script[i].typed, script[i].want);
			end
		end

		for (int p = 0; p < 8; p++) begin
			drain_results();
			if (p == 7)
				traffic_gaps = 1'b0;
			write_register(REG_DEBOUNCE, 8'(deb_plan[p]));
			write_register(REG_DWELL, 8'(dwell_plan[p]));
			sent = 0;
			while (sent < budget_plan[p]) begin
				if ($urandom_range(0, 4) != 0) begin
					// press held around the debounce count, then released
					lim = (debounce_reg == 8'd0) ? 1 : int'(debounce_reg);
					case ($urandom_range(0, 3))
						0: hold = (lim > 1) ? lim - 1 : 1;
						1: hold = lim;
						2: hold = lim + $urandom_range(1, 12);
						default: hold = $urandom_range(1, 2 * lim);
					endcase
					for (k = 0; k < hold && sent < budget_plan[p]; k++) begin
						send_tick(pick_switch(), 1'b1, 1'b0, '0);
						sent++;
					end
					repeat ($urandom_range(1, 6)) begin
						send_tick(pick_switch(), 1'b0, 1'b0, '0);
						sent++;
					end
				end else begin
					// bouncing button
					repeat ($urandom_range(1, 8)) begin
						send_tick(pick_switch(), 1'($urandom_range(0, 1)), 1'b0, '0);
						sent++;
					end
				end
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/mss_pkg.sv
design/multibase_seven_segment_scanner.sv
tb/sv/multibase_seven_segment_scanner_test.sv
